>>> rtl/assert_macros.svh
// Assertion macros for the RTL files that carry checks.
// Depends on clk and arst_n being visible where a macro is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising edge, held off during reset.
`define JKV_ASSERT_IMPLY(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Plain condition checked on every rising edge, held off during reset.
`define JKV_ASSERT_ALWAYS(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error(msg);

`endif

>>> rtl/jkv_pkg.sv
// Package for the JSON key/value extractor: sizes, character codes,
// register indexes and the transaction types of both channels. No dependencies.
`default_nettype none

package jkv_pkg;

	localparam int MAX_KEY_LEN = 16;
	localparam int DEPTH_BITS  = 16;

	localparam int KEY_CHARS = 16;
	localparam int KIDX_W    = $clog2(KEY_CHARS);
	localparam int KEY_CAP   = (MAX_KEY_LEN < KEY_CHARS) ? MAX_KEY_LEN : KEY_CHARS;
	localparam int KLEN_W    = 5;
	localparam int WIN_LEN   = MAX_KEY_LEN + 3;
	localparam int SEEN_W    = $clog2(WIN_LEN + 1);
	localparam int CFG_IDX_W = 2;
	localparam int CFG_W     = 64;

	localparam logic [CFG_IDX_W-1:0] CFG_KEY_LO = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_KEY_HI = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_KEY_LEN = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_MODE = 2'd3;

	localparam logic [7:0] CH_NUL    = 8'h00;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_COMMA  = 8'h2C;
	localparam logic [7:0] CH_MINUS  = 8'h2D;
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_NINE   = 8'h39;
	localparam logic [7:0] CH_COLON  = 8'h3A;
	localparam logic [7:0] CH_LBRACK = 8'h5B;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_RBRACK = 8'h5D;
	localparam logic [7:0] CH_LBRACE = 8'h7B;
	localparam logic [7:0] CH_RBRACE = 8'h7D;

	typedef logic [WIN_LEN-1:0][7:0] window_t;

	typedef struct packed {
		logic [7:0] text_byte;
		logic       doc_last;
	} text_t;

	typedef struct packed {
		logic [7:0]         value_byte;
		logic               byte_valid;
		logic               value_done;
		logic               found;
		logic signed [63:0] int_result;
	} result_t;

endpackage

`default_nettype wire

>>> rtl/json_key_value_extractor_top.sv
// A result is registered in the output buffer (output or skid register) as its byte is accepted.
// One byte per cycle while text_stall is low; window compare and next-state logic are combinational.
// stall rises only while both output buffer entries hold results.
// Reset (arst_n low) clears document state, config registers and the buffer at once.
// Top level of the JSON key/value extractor. Depends on jkv_pkg, jkv_core,
// jkv_outbuf and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module json_key_value_extractor_top (
	input  var logic                          clk,
	input  var logic                          arst_n,
	input  var logic                          text_valid,
	output var logic                          text_stall,
	input  var jkv_pkg::text_t                text,
	output var logic                          result_valid,
	input  var logic                          result_stall,
	output var jkv_pkg::result_t              result,
	input  var logic                          cfg_wr_en,
	input  var logic [jkv_pkg::CFG_IDX_W-1:0] cfg_index,
	input  var logic [jkv_pkg::CFG_W-1:0]     cfg_data
);
	import jkv_pkg::*;

	logic    accept;
	logic    res_en;
	result_t res;
	logic    buf_full;

	assign text_stall = buf_full;
	assign accept     = text_valid && !text_stall;

	jkv_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.text      (text),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.res       (res),
		.res_en    (res_en)
	);

	jkv_outbuf u_outbuf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (accept && res_en),
		.push_data (res),
		.out_stall (result_stall),
		.out_valid (result_valid),
		.out_data  (result),
		.full      (buf_full)
	);

	`JKV_ASSERT_IMPLY(a_stall_needs_result, text_stall, result_valid, "stall without a held result")
	`JKV_ASSERT_IMPLY(a_stall_rise_cause, $rose(text_stall), $past(result_valid && result_stall), "stall rose without output backpressure")
	`JKV_ASSERT_IMPLY(a_byte_result_form, result_valid && result.byte_valid, result.found && (result.int_result == 64'sd0), "byte transaction malformed")

endmodule

`default_nettype wire

>>> rtl/jkv_match.sv
// Marker comparator: checks the byte window for the quoted key and colon.
// Depends on jkv_pkg.
`default_nettype none

module jkv_match (
	input  var jkv_pkg::window_t            win,
	input  var logic [jkv_pkg::SEEN_W-1:0]  seen,
	input  var logic [jkv_pkg::KLEN_W-1:0]  key_len,
	input  var logic [63:0]                 key_lo,
	input  var logic [63:0]                 key_hi,
	output var logic                        hit
);
	import jkv_pkg::*;

	logic [KEY_CHARS-1:0][7:0] key;
	logic [SEEN_W-1:0]         need;

	assign key  = {key_hi, key_lo};
	assign need = SEEN_W'(key_len) + SEEN_W'(3);

	always_comb begin
		logic [7:0] pos;
		logic [7:0] len8;
		logic [7:0] kidx;
		logic [7:0] expect_byte;
		len8 = 8'(key_len);
		pos = 8'd0;
		kidx = 8'd0;
		expect_byte = CH_NUL;
		hit = (seen >= need);
		// k counts back from the newest byte
		for (int k = 0; k < WIN_LEN; k++) begin
			pos = 8'(k);
			kidx = len8 + 8'd1 - pos;
			if (pos == 8'd0)
				expect_byte = CH_COLON;
			else if (pos == 8'd1 || pos == len8 + 8'd2)
				expect_byte = CH_QUOTE;
			else
				expect_byte = key[kidx[KIDX_W-1:0]];
			if ((pos <= len8 + 8'd2) && (win[WIN_LEN-1-k] != expect_byte))
				hit = 1'b0;
		end
	end

endmodule

`default_nettype wire

>>> rtl/jkv_core.sv
// Scanner core: configuration registers, document state and the per-byte
// update that yields at most one result. Depends on jkv_pkg and jkv_match.
`default_nettype none

module jkv_core (
	input  var logic                          clk,
	input  var logic                          arst_n,
	input  var logic                          accept,
	input  var jkv_pkg::text_t                text,
	input  var logic                          cfg_wr_en,
	input  var logic [jkv_pkg::CFG_IDX_W-1:0] cfg_index,
	input  var logic [jkv_pkg::CFG_W-1:0]     cfg_data,
	output var jkv_pkg::result_t              res,
	output var logic                          res_en
);
	import jkv_pkg::*;

	typedef enum logic [2:0] {
		PH_SEARCH,
		PH_SKIP,
		PH_RAW,
		PH_NUM_FIRST,
		PH_NUM_MORE,
		PH_DONE
	} phase_t;

	localparam logic [DEPTH_BITS-1:0] DEPTH_MAX = {DEPTH_BITS{1'b1}};
	localparam logic [SEEN_W-1:0]     SEEN_MAX  = SEEN_W'(WIN_LEN);
	localparam logic [KLEN_W-1:0]     KLEN_CAP  = KLEN_W'(KEY_CAP);

	logic [63:0]       key_lo_q, key_hi_q;
	logic [KLEN_W-1:0] key_len_q;
	logic              mode_q;

	phase_t                phase_q, phase_n;
	logic [SEEN_W-1:0]     seen_q, seen_n, seen_inc;
	logic [DEPTH_BITS-1:0] depth_q, depth_n;
	logic                  in_str_q, in_str_n;
	logic                  bslash_q, bslash_n;
	logic [63:0]           acc_q, acc_n;
	logic                  neg_q, neg_n;
	window_t               win_q, win_sh;

	logic [KLEN_W-1:0] eff_len;
	logic              hit;
	logic [7:0]        c;

	assign c        = text.text_byte;
	assign eff_len  = (key_len_q > KLEN_CAP) ? KLEN_CAP : key_len_q;
	assign seen_inc = (seen_q < SEEN_MAX) ? seen_q + SEEN_W'(1) : seen_q;

	always_comb begin
		win_sh[WIN_LEN-2:0] = win_q[WIN_LEN-1:1];
		win_sh[WIN_LEN-1]   = c;
	end

	jkv_match u_match (
		.win     (win_sh),
		.seen    (seen_inc),
		.key_len (eff_len),
		.key_lo  (key_lo_q),
		.key_hi  (key_hi_q),
		.hit     (hit)
	);

	always_comb begin
		logic        raw_go, num_go, num_first;
		logic        emit, fin, fin_found;
		logic        is_digit, is_blank, is_delim;
		logic [63:0] digit, dterm, int_val;
		raw_go    = 1'b0;
		num_go    = 1'b0;
		num_first = 1'b0;
		emit      = 1'b0;
		fin       = 1'b0;
		fin_found = 1'b0;
		int_val   = 64'd0;
		is_digit  = (c >= CH_ZERO) && (c <= CH_NINE);
		is_blank  = (c == CH_SPACE) || (c == CH_TAB) || (c == CH_LF);
		is_delim  = is_blank || (c == CH_COMMA) || (c == CH_CR);
		digit     = {60'd0, c[3:0]};
		dterm     = neg_q ? (64'd0 - digit) : digit;

		phase_n  = phase_q;
		seen_n   = seen_q;
		depth_n  = depth_q;
		in_str_n = in_str_q;
		bslash_n = bslash_q;
		acc_n    = acc_q;
		neg_n    = neg_q;

		if (c != CH_NUL) begin
			unique case (phase_q)
				PH_SEARCH: begin
					seen_n = seen_inc;
					if (hit)
						phase_n = PH_SKIP;
				end
				PH_SKIP: begin
					if (!is_blank) begin
						if (mode_q) begin
							phase_n = PH_NUM_FIRST;
							if (c == CH_MINUS) begin
								neg_n = 1'b1;
							end else begin
								num_go    = 1'b1;
								num_first = 1'b1;
							end
						end else begin
							raw_go = 1'b1;
						end
					end
				end
				PH_RAW: raw_go = 1'b1;
				PH_NUM_FIRST: begin
					num_go    = 1'b1;
					num_first = 1'b1;
				end
				PH_NUM_MORE: num_go = 1'b1;
				PH_DONE: ;
				default: ;
			endcase
		end

		if (raw_go) begin
			if (in_str_q) begin
				if (bslash_q)
					bslash_n = 1'b0;
				else if (c == CH_BSLASH)
					bslash_n = 1'b1;
				else if (c == CH_QUOTE)
					in_str_n = 1'b0;
				emit = 1'b1;
			end else if (c == CH_QUOTE) begin
				in_str_n = 1'b1;
				emit = 1'b1;
			end else if (c == CH_LBRACE || c == CH_LBRACK) begin
				if (depth_q != DEPTH_MAX)
					depth_n = depth_q + DEPTH_BITS'(1);
				emit = 1'b1;
			end else if (c == CH_RBRACE || c == CH_RBRACK) begin
				emit = 1'b1;
				if (depth_q == '0) begin
					fin = 1'b1;
					fin_found = 1'b1;
				end else begin
					depth_n = depth_q - DEPTH_BITS'(1);
				end
			end else if (depth_q == '0 && is_delim) begin
				fin = 1'b1;
				fin_found = (phase_q == PH_RAW);
			end else begin
				emit = 1'b1;
			end
			if (!fin)
				phase_n = PH_RAW;
		end

		if (num_go) begin
			if (!is_digit) begin
				fin = 1'b1;
				fin_found = !num_first;
				int_val = num_first ? 64'd0 : acc_q;
			end else begin
				// x10 as two shifted adds
				acc_n = num_first ? dterm : (acc_q << 3) + (acc_q << 1) + dterm;
				phase_n = PH_NUM_MORE;
			end
		end

		if (fin)
			phase_n = PH_DONE;

		// end of text: doc_last or a zero byte
		if ((text.doc_last || c == CH_NUL) && phase_n != PH_DONE) begin
			fin = 1'b1;
			fin_found = (phase_n == PH_RAW) || (phase_n == PH_NUM_MORE);
			int_val = (phase_n == PH_NUM_MORE) ? acc_n : 64'd0;
			phase_n = PH_DONE;
		end

		res.value_byte = emit ? c : CH_NUL;
		res.byte_valid = emit;
		res.value_done = fin;
		res.found      = emit | fin_found;
		res.int_result = int_val;
		res_en         = emit | fin;

		if (text.doc_last) begin
			phase_n  = PH_SEARCH;
			seen_n   = '0;
			depth_n  = '0;
			in_str_n = 1'b0;
			bslash_n = 1'b0;
			acc_n    = 64'd0;
			neg_n    = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_lo_q  <= 64'd0;
			key_hi_q  <= 64'd0;
			key_len_q <= '0;
			mode_q    <= 1'b0;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				CFG_KEY_LO:  key_lo_q <= cfg_data;
				CFG_KEY_HI:  key_hi_q <= cfg_data;
				CFG_KEY_LEN: key_len_q <= cfg_data[KLEN_W-1:0];
				CFG_MODE:    mode_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_SEARCH;
			seen_q   <= '0;
			depth_q  <= '0;
			in_str_q <= 1'b0;
			bslash_q <= 1'b0;
			acc_q    <= 64'd0;
			neg_q    <= 1'b0;
		end else if (accept) begin
			phase_q  <= phase_n;
			seen_q   <= seen_n;
			depth_q  <= depth_n;
			in_str_q <= in_str_n;
			bslash_q <= bslash_n;
			acc_q    <= acc_n;
			neg_q    <= neg_n;
		end
	end

	// window contents only count once seen_q covers them
	always_ff @(posedge clk) begin
		if (accept && phase_q == PH_SEARCH && c != CH_NUL)
			win_q <= win_sh;
	end

endmodule

`default_nettype wire

>>> rtl/jkv_outbuf.sv
// Two-entry output buffer: result register plus skid register.
// Depends on jkv_pkg.
`default_nettype none

module jkv_outbuf (
	input  var logic             clk,
	input  var logic             arst_n,
	input  var logic             push,
	input  var jkv_pkg::result_t push_data,
	input  var logic             out_stall,
	output var logic             out_valid,
	output var jkv_pkg::result_t out_data,
	output var logic             full
);
	import jkv_pkg::*;

	logic    main_v_q, skid_v_q;
	result_t main_q, skid_q;
	logic    room;

	assign room      = !main_v_q || !out_stall;
	assign out_valid = main_v_q;
	assign out_data  = main_q;
	assign full      = skid_v_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_v_q <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (room) begin
			main_v_q <= skid_v_q || push;
			skid_v_q <= 1'b0;
		end else if (push) begin
			skid_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (room) begin
			if (skid_v_q)
				main_q <= skid_q;
			else if (push)
				main_q <= push_data;
		end else if (push) begin
			skid_q <= push_data;
		end
	end

endmodule

`default_nettype wire

>>> tb/json_key_value_extractor_top_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for json_key_value_extractor_top: random JSON documents with
// random idling on both channels, checked against a predictor of the key scan.
// Depends on jkv_pkg and the extractor RTL.

module json_key_value_extractor_top_tb;
	import jkv_pkg::*;

	localparam int CYCLE_LIMIT = 1000000;

	typedef enum logic [2:0] {
		SEARCHING, SKIP_BLANK, RAW_VALUE, NUM_FIRST, NUM_MORE, FINISHED
	} scan_phase_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic text_valid = 1'b0;
	logic text_stall;
	text_t text = '0;
	logic result_valid;
	logic result_stall = 1'b0;
	result_t result;
	logic cfg_wr_en = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0] cfg_data = '0;

	// key registers as the block holds them
	logic [63:0] key_lo = '0;
	logic [63:0] key_hi = '0;
	logic [KLEN_W-1:0] key_len = '0;
	bit int_mode = 1'b0;

	// per-document scan state
	logic [7:0] scan_win [WIN_LEN];
	int scan_seen;
	scan_phase_t scan_phase;
	logic [DEPTH_BITS-1:0] nest;
	bit in_str, escaped, num_neg;
	logic [63:0] num_acc;

	result_t cur, want;
	result_t extracted [$];
	text_t doc_feed [$];
	logic [7:0] doc_text [$];

	int queued = 0, taken = 0, errors = 0, cycles = 0;
	int send_idle = 0, stall_left = 0, hold_left = 0;
	bit text_fire = 1'b0, quiet = 1'b0, hold_req = 1'b0, hold_done = 1'b0;

	json_key_value_extractor_top uut (
		.clk,
		.arst_n,
		.text_valid,
		.text_stall,
		.text,
		.result_valid,
		.result_stall,
		.result,
		.cfg_wr_en,
		.cfg_index,
		.cfg_data
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic int key_span();
		int l;
		l = key_len;
		if (l > KEY_CAP) l = KEY_CAP;
		return l;
	endfunction

	function automatic logic [7:0] marker_char(int j, int l);
		if (j == 0 || j == l + 1) return CH_QUOTE;
		if (j == l + 2) return CH_COLON;
		if (j < 9) return key_lo[8*(j-1) +: 8];
		return key_hi[8*(j-9) +: 8];
	endfunction

	function automatic logic [7:0] rand_key_char();
		if ($urandom_range(0, 7) == 0) return 8'($urandom_range(33, 126));
		return 8'($urandom_range(97, 122));
	endfunction

	function automatic logic [63:0] num_value();
		return num_neg ? -num_acc : num_acc;
	endfunction

	task automatic clear_doc();
		foreach (scan_win[i]) scan_win[i] = '0;
		scan_seen = 0;
		scan_phase = SEARCHING;
		nest = '0;
		in_str = 1'b0;
		escaped = 1'b0;
		num_acc = '0;
		num_neg = 1'b0;
	endtask

	task automatic finish_value(input bit fnd, input logic [63:0] val);
		cur.value_done = 1'b1;
		cur.found = fnd;
		cur.int_result = val;
		scan_phase = FINISHED;
	endtask

	task automatic give_byte(input logic [7:0] c);
		cur.byte_valid = 1'b1;
		cur.value_byte = c;
		cur.found = 1'b1;
	endtask

	task automatic raw_byte(input logic [7:0] c);
		if (in_str) begin
			if (escaped) escaped = 1'b0;
			else if (c == CH_BSLASH) escaped = 1'b1;
			else if (c == CH_QUOTE) in_str = 1'b0;
			give_byte(c);
		end else if (c == CH_QUOTE) begin
			in_str = 1'b1;
			give_byte(c);
		end else if (c == CH_LBRACE || c == CH_LBRACK) begin
			if (nest != '1) nest++;
			give_byte(c);
		end else if (c == CH_RBRACE || c == CH_RBRACK) begin
			give_byte(c);
			if (nest == '0) finish_value(1'b1, '0);
			else nest--;
		end else if (nest == '0 && (c == CH_COMMA || c == CH_LF || c == CH_CR ||
				c == CH_SPACE || c == CH_TAB)) begin
			finish_value(scan_phase == RAW_VALUE, '0);
		end else begin
			give_byte(c);
		end
		if (scan_phase == SKIP_BLANK) scan_phase = RAW_VALUE;
	endtask

	task automatic num_byte(input logic [7:0] c);
		bit digit;
		digit = (c >= CH_ZERO && c <= CH_NINE);
		if (scan_phase == NUM_FIRST) begin
			if (!digit) begin
				finish_value(1'b0, '0);
			end else begin
				num_acc = 64'(c - CH_ZERO);
				scan_phase = NUM_MORE;
			end
		end else if (!digit) begin
			finish_value(1'b1, num_value());
		end else begin
			num_acc = num_acc * 64'd10 + 64'(c - CH_ZERO);
		end
	endtask

	// works out the result, if any, of one accepted text byte
	task automatic extract_step(input text_t t);
		logic [7:0] c;
		bit last, hit;
		int l, m, i;
		c = t.text_byte;
		last = t.doc_last;
		cur = '0;
		if (c != CH_NUL && scan_phase != FINISHED) begin
			case (scan_phase)
				SEARCHING: begin
					l = key_span();
					m = l + 3;
					for (i = 0; i < WIN_LEN - 1; i++) scan_win[i] = scan_win[i+1];
					scan_win[WIN_LEN-1] = c;
					if (scan_seen < WIN_LEN) scan_seen++;
					if (scan_seen >= m) begin
						hit = 1'b1;
						for (i = 0; i < m; i++)
							if (scan_win[WIN_LEN-m+i] != marker_char(i, l)) hit = 1'b0;
						if (hit) scan_phase = SKIP_BLANK;
					end
				end
				SKIP_BLANK: begin
					if (!(c == CH_SPACE || c == CH_TAB || c == CH_LF)) begin
						if (int_mode) begin
							scan_phase = NUM_FIRST;
							if (c == CH_MINUS) num_neg = 1'b1;
							else num_byte(c);
						end else begin
							raw_byte(c);
						end
					end
				end
				RAW_VALUE: raw_byte(c);
				default: num_byte(c);
			endcase
		end
		if ((last || c == CH_NUL) && scan_phase != FINISHED && !cur.value_done) begin
			if (scan_phase == RAW_VALUE) finish_value(1'b1, '0);
			else if (scan_phase == NUM_MORE) finish_value(1'b1, num_value());
			else finish_value(1'b0, '0);
		end
		if (last) clear_doc();
		if (cur.byte_valid || cur.value_done) extracted.push_back(cur);
	endtask

	task automatic report_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] exp_val);
		if (errors < 200)
			$display("%0t mismatch on %s: got %h, expected %h", $time, what, got, exp_val);
		errors++;
	endtask

	task automatic put(input logic [7:0] c);
		doc_text.push_back(c);
	endtask

	task automatic put_str(input string s);
		int i;
		for (i = 0; i < s.len(); i++) put(s[i]);
	endtask

	task automatic close_doc();
		text_t ti;
		int i;
		for (i = 0; i < doc_text.size(); i++) begin
			ti.text_byte = doc_text[i];
			ti.doc_last = (i == doc_text.size() - 1);
			doc_feed.push_back(ti);
			queued++;
		end
		doc_text.delete();
	endtask

	task automatic drain();
		while (taken != queued || extracted.size() != 0) @(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
		@(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		case (idx)
			CFG_KEY_LO: key_lo = data;
			CFG_KEY_HI: key_hi = data;
			CFG_KEY_LEN: key_len = data[KLEN_W-1:0];
			CFG_MODE: int_mode = data[0];
		endcase
	endtask

	task automatic set_config(input logic [63:0] lo, input logic [63:0] hi, input int len,
			input bit mode);
		write_reg(CFG_KEY_LO, lo);
		write_reg(CFG_KEY_HI, hi);
		write_reg(CFG_KEY_LEN, 64'(len));
		write_reg(CFG_MODE, 64'(mode));
		@(negedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	// byte sender
	always @(negedge clk) begin
		if (arst_n && (!text_valid || text_fire)) begin
			if (send_idle > 0) begin
				send_idle--;
				text_valid <= 1'b0;
			end else if (doc_feed.size() > 0 && !quiet && $urandom_range(0, 11) == 0) begin
				send_idle = $urandom_range(0, 14);
				text_valid <= 1'b0;
			end else if (doc_feed.size() > 0) begin
				text <= doc_feed.pop_front();
				text_valid <= 1'b1;
			end else begin
				text_valid <= 1'b0;
			end
		end
	end

	// result receiver stalls, with one long hold-off
	always @(negedge clk) begin
		if (hold_req && !hold_done) begin
			hold_left = 400;
			hold_done = 1'b1;
		end
		if (hold_left > 0) begin
			hold_left--;
			result_stall <= 1'b1;
		end else if (stall_left > 0) begin
			stall_left--;
			result_stall <= 1'b1;
		end else if (!quiet && $urandom_range(0, 9) == 0) begin
			stall_left = $urandom_range(0, 14);
			result_stall <= 1'b1;
		end else begin
			result_stall <= 1'b0;
		end
	end

	always @(posedge clk) begin
		text_fire = text_valid && !text_stall;
		if (arst_n) begin
			if (text_fire) begin
				extract_step(text);
				taken++;
			end
			if (result_valid && !result_stall) begin
				if (extracted.size() == 0) begin
					report_mismatch("unexpected transaction", result.int_result, '0);
				end else begin
					want = extracted.pop_front();
					if (result.value_byte !== want.value_byte)
						report_mismatch("value_byte", 64'(result.value_byte), 64'(want.value_byte));
					if (result.byte_valid !== want.byte_valid)
						report_mismatch("byte_valid", 64'(result.byte_valid), 64'(want.byte_valid));
					if (result.value_done !== want.value_done)
						report_mismatch("value_done", 64'(result.value_done), 64'(want.value_done));
					if (result.found !== want.found)
						report_mismatch("found", 64'(result.found), 64'(want.found));
					if (result.int_result !== want.int_result)
						report_mismatch("int_result", result.int_result, want.int_result);
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	initial begin : stimulus
		logic [63:0] new_lo, new_hi;
		logic [7:0] closers [$];
		int new_len, i, j, n, p, l, target, kind;
		bit new_mode;
		clear_doc();
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// reset settings: empty key, raw values
		put_str("\"\": }");
		close_doc();
		put_str("\"\":,");
		close_doc();
		put_str("\"\":");
		put(CH_NUL);
		put("x");
		close_doc();
		put(8'hFF);
		close_doc();
		drain();
		set_config('0, '0, 0, 1'b1);
		put_str("\"\":-");
		close_doc();
		put_str("\"\":\t9");
		close_doc();

		for (p = 0; p < 8; p++) begin
			drain();
			for (i = 0; i < 8; i++) begin
				new_lo[8*i +: 8] = rand_key_char();
				new_hi[8*i +: 8] = rand_key_char();
			end
			new_mode = p[0];
			case (p)
				0: begin
					new_lo = {48'd0, "di"};
					new_len = 2;
				end
				1: new_len = 16;
				2: new_len = 31;
				3: new_len = 1;
				4: begin
					// all-ones low key half with a NUL character: never matches
					new_lo = '1;
					new_hi[15:8] = CH_NUL;
					new_len = 31;
					new_mode = $urandom_range(0, 1);
				end
				5: new_len = 0;
				6: begin
					new_len = $urandom_range(1, 16);
					new_mode = $urandom_range(0, 1);
				end
				default: begin
					new_len = $urandom_range(3, 12);
					new_mode = 1'b0;
				end
			endcase
			set_config(new_lo, new_hi, new_len, new_mode);
			if (p == 0) hold_req = 1'b1;
			if (p == 7) quiet = 1'b1;
			l = key_span();
			target = queued + 180;
			while (queued < target) begin
				kind = $urandom_range(0, 9);
				if (kind == 0) begin
					n = $urandom_range(1, 24);
					for (i = 0; i < n; i++)
						put(($urandom_range(0, 19) == 0) ? CH_NUL : 8'($urandom_range(1, 255)));
				end else begin
					if ($urandom_range(0, 1)) put_str("{\"a\":[1,\"}\"], ");
					if (kind == 1) begin
						// marker cut short
						n = $urandom_range(0, l + 2);
						for (i = 0; i < n; i++) put(marker_char(i, l));
						put_str(" 1,");
					end else begin
						for (i = 0; i < l + 3; i++) put(marker_char(i, l));
						n = $urandom_range(0, 3);
						for (i = 0; i < n; i++)
							case ($urandom_range(0, 2))
								0: put(CH_SPACE);
								1: put(CH_TAB);
								default: put(CH_LF);
							endcase
						case ($urandom_range(0, 6))
							0, 1: begin
								if ($urandom_range(0, 1)) put(CH_MINUS);
								n = ($urandom_range(0, 4) == 0) ? $urandom_range(17, 22)
									: $urandom_range(0, 5);
								for (i = 0; i < n; i++) put(8'(CH_ZERO + $urandom_range(0, 9)));
								if ($urandom_range(0, 5) == 0) put_str(".5");
							end
							2: begin
								put(CH_QUOTE);
								n = $urandom_range(0, 8);
								for (i = 0; i < n; i++)
									case ($urandom_range(0, 7))
										0: begin
											put(CH_BSLASH);
											put(($urandom_range(0, 2) == 0) ? CH_QUOTE
												: ($urandom_range(0, 1) ? CH_BSLASH : "n"));
										end
										1: put(CH_LBRACE);
										2: put(CH_RBRACE);
										3: put(CH_COMMA);
										4: put(CH_SPACE);
										5: put(CH_RBRACK);
										default: put(8'($urandom_range(97, 122)));
									endcase
								put(CH_QUOTE);
							end
							3: begin
								closers.delete();
								n = $urandom_range(1, 3);
								for (i = 0; i < n; i++) begin
									if ($urandom_range(0, 1)) begin
										put(CH_LBRACK);
										closers.push_front(CH_RBRACK);
									end else begin
										put(CH_LBRACE);
										closers.push_front(CH_RBRACE);
									end
									put_str("\"s ,}]\\\"\", ");
								end
								for (j = 0; j < closers.size(); j++) put(closers[j]);
							end
							4: begin
								case ($urandom_range(0, 2))
									0: put_str("true");
									1: put_str("false");
									default: put_str("null");
								endcase
							end
							5: begin
								n = $urandom_range(1, 4);
								for (i = 0; i < n; i++) put(8'($urandom_range(1, 255)));
							end
							default: ;
						endcase
						case ($urandom_range(0, 7))
							0: put(CH_COMMA);
							1: put(CH_SPACE);
							2: put(CH_RBRACE);
							3: put(CH_CR);
							4: put(CH_RBRACK);
							5: put(CH_TAB);
							6: put(CH_LF);
							default: ;
						endcase
						if ($urandom_range(0, 3) == 0) put_str("\"b\":2}");
						if ($urandom_range(0, 15) == 0) begin
							put(CH_NUL);
							put_str("1");
						end
					end
				end
				if (doc_text.size() == 0) put("x");
				close_doc();
			end
		end

		// deep nesting that one closer does not unwind, ended by the document end
		for (i = 0; i < l + 3; i++) put(marker_char(i, l));
		for (i = 0; i < 24; i++) put(CH_LBRACK);
		put(CH_RBRACK);
		put(CH_COMMA);
		put("x");
		close_doc();
		drain();
		if (errors == 0 && extracted.size() == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule
